// ===== rtl/mbrs_pkg.sv =====
`default_nettype none

package mbrs_pkg;

    // Store geometry and read limit
    localparam int STORE_DEPTH    = 1024;
    localparam int MAX_READ_WORDS = 64;
    localparam int ADDR_W         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CLR_W          = ADDR_W + 1;
    localparam int QTY_W          = $clog2(MAX_READ_WORDS + 1);
    localparam bit DEPTH_POW2     = ((STORE_DEPTH & (STORE_DEPTH - 1)) == 0);
    localparam int RED_STEPS      = 17 - ADDR_W;

    // Command queue between front and back, result queue at the output
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // Function codes
    localparam logic [7:0] FN_READ_HOLDING = 8'h03;
    localparam logic [7:0] FN_READ_INPUT   = 8'h04;
    localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;

    // Result status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_BAD_FUNCTION = 2'd1;
    localparam logic [1:0] ST_BAD_VALUE    = 2'd2;

    // Command kinds after classification
    localparam logic [1:0] K_READ  = 2'd0;
    localparam logic [1:0] K_WRITE = 2'd1;
    localparam logic [1:0] K_REPLY = 2'd2;

    typedef struct packed {
        logic [7:0]  unit_address;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] quantity;
        logic [7:0]  data_count;
        logic [7:0]  data_high;
        logic [7:0]  data_low;
    } t_req;

    typedef struct packed {
        logic [7:0]  unit_echo;
        logic [7:0]  function_echo;
        logic [1:0]  status;
        logic        word_valid;
        logic [15:0] data_word;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        unit;
        logic [7:0]        fn;
        logic [1:0]        status;
        logic [15:0]       a16;
        logic [ADDR_W-1:0] idx;
        logic [QTY_W-1:0]  qty;
        logic [15:0]       word;
    } t_cmd;

    // Reduce a 16-bit register address to a store index
    function automatic logic [ADDR_W-1:0] store_index(input logic [15:0] addr);
        logic [16:0] r;
        r = {1'b0, addr};
        if (!DEPTH_POW2) begin
            for (int k = RED_STEPS - 1; k >= 0; k--) begin
                if (r >= (17'(STORE_DEPTH) << k)) begin
                    r = r - (17'(STORE_DEPTH) << k);
                end
            end
        end
        return r[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mbrs_ram.sv =====
`default_nettype none

module mbrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/mbrs_front.sv =====
`default_nettype none

module mbrs_front import mbrs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_req i_req,
    input  wire logic i_hold,
    output logic      o_full,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_pop
);

    t_cmd                r_q [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wp;
    logic [CQ_PTR_W-1:0] r_rp;
    logic [CQ_CNT_W-1:0] r_cnt;
    logic [CQ_CNT_W-1:0] n_cnt;
    t_cmd                cls;
    logic                wr;
    logic                rd;

    // Classify the request into a command for the back end
    always_comb begin
        cls        = '0;
        cls.unit   = i_req.unit_address;
        cls.fn     = i_req.function_code;
        cls.a16    = i_req.start_address;
        cls.idx    = store_index(i_req.start_address);
        cls.kind   = K_REPLY;
        cls.status = ST_OK;
        unique case (i_req.function_code) inside
            FN_READ_HOLDING, FN_READ_INPUT: begin
                if (i_req.quantity > 16'(MAX_READ_WORDS)) begin
                    cls.status = ST_BAD_VALUE;
                end else if (i_req.quantity != 16'd0) begin
                    cls.kind = K_READ;
                    cls.qty  = i_req.quantity[QTY_W-1:0];
                end
            end
            FN_WRITE_SINGLE: begin
                if (i_req.data_count >= 8'd2) begin
                    cls.kind = K_WRITE;
                    cls.word = {i_req.data_high, i_req.data_low};
                end else begin
                    cls.status = ST_BAD_VALUE;
                end
            end
            default: begin
                cls.status = ST_BAD_FUNCTION;
            end
        endcase
    end

    assign o_full      = (r_cnt == CQ_CNT_W'(CQ_DEPTH)) || i_hold;
    assign wr          = i_push && !o_full;
    assign rd          = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + CQ_CNT_W'(1);
        end else if (rd && !wr) begin
            n_cnt = r_cnt - CQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr) begin
                r_wp <= r_wp + CQ_PTR_W'(1);
            end
            if (rd) begin
                r_rp <= r_rp + CQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mbrs_back.sv =====
`default_nettype none

module mbrs_back import mbrs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output logic      o_clearing,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_rsp      o_rsp
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [CLR_W-1:0]    r_clr_idx;
    logic [7:0]          r_unit;
    logic [7:0]          n_unit;
    logic [7:0]          r_fn;
    logic [7:0]          n_fn;
    logic [15:0]         r_a16;
    logic [15:0]         n_a16;
    logic [ADDR_W-1:0]   r_idx;
    logic [ADDR_W-1:0]   n_idx;
    logic [QTY_W-1:0]    r_left;
    logic [QTY_W-1:0]    n_left;
    logic                r_pend;
    logic                n_pend;
    logic [7:0]          r_p_unit;
    logic [7:0]          r_p_fn;
    logic                r_p_last;
    logic                issue;

    t_rsp                r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_owp;
    logic [OQ_PTR_W-1:0] r_orp;
    logic [OQ_CNT_W-1:0] r_ocnt;
    logic                room;
    logic                q_push;
    logic                q_pop;
    t_rsp                q_data;
    logic                imm_push;
    t_rsp                imm_rsp;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [15:0]         ram_wdata;
    logic [15:0]         ram_rdata;

    mbrs_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Count a read in flight against the result queue space
    assign room = (r_ocnt + OQ_CNT_W'(r_pend)) < OQ_CNT_W'(OQ_DEPTH);

    always_comb begin
        n_state   = r_state;
        n_unit    = r_unit;
        n_fn      = r_fn;
        n_a16     = r_a16;
        n_idx     = r_idx;
        n_left    = r_left;
        issue     = 1'b0;
        o_cmd_pop = 1'b0;
        imm_push  = 1'b0;
        imm_rsp   = '0;
        ram_we    = 1'b0;
        ram_waddr = i_cmd.idx;
        ram_wdata = i_cmd.word;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx[ADDR_W-1:0];
                ram_wdata = '0;
                if (r_clr_idx == CLR_W'(STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && room) begin
                    imm_rsp.unit_echo     = i_cmd.unit;
                    imm_rsp.function_echo = i_cmd.fn;
                    imm_rsp.last          = 1'b1;
                    unique case (i_cmd.kind)
                        K_READ: begin
                            o_cmd_pop = 1'b1;
                            n_unit    = i_cmd.unit;
                            n_fn      = i_cmd.fn;
                            n_a16     = i_cmd.a16;
                            n_idx     = i_cmd.idx;
                            n_left    = i_cmd.qty;
                            n_state   = S_READ;
                        end
                        K_WRITE: begin
                            if (!r_pend) begin
                                o_cmd_pop          = 1'b1;
                                ram_we             = 1'b1;
                                imm_push           = 1'b1;
                                imm_rsp.status     = ST_OK;
                                imm_rsp.word_valid = 1'b1;
                                imm_rsp.data_word  = i_cmd.word;
                            end
                        end
                        default: begin
                            if (!r_pend) begin
                                o_cmd_pop      = 1'b1;
                                imm_push       = 1'b1;
                                imm_rsp.status = i_cmd.status;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                if (room) begin
                    issue  = 1'b1;
                    n_a16  = r_a16 + 16'd1;
                    n_left = r_left - QTY_W'(1);
                    if (r_a16 == 16'hFFFF || r_idx == ADDR_W'(STORE_DEPTH - 1)) begin
                        n_idx = '0;
                    end else begin
                        n_idx = r_idx + ADDR_W'(1);
                    end
                    if (r_left == QTY_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_pend = issue;

    // Read data lands in the cycle after issue and takes priority in the queue
    always_comb begin
        q_push = r_pend || imm_push;
        if (r_pend) begin
            q_data.unit_echo     = r_p_unit;
            q_data.function_echo = r_p_fn;
            q_data.status        = ST_OK;
            q_data.word_valid    = 1'b1;
            q_data.data_word     = ram_rdata;
            q_data.last          = r_p_last;
        end else begin
            q_data = imm_rsp;
        end
    end

    assign o_empty    = (r_ocnt == '0);
    assign q_pop      = i_pop && !o_empty;
    assign o_rsp      = r_oq[r_orp];
    assign o_clearing = (r_state == S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_pend    <= 1'b0;
            r_owp     <= '0;
            r_orp     <= '0;
            r_ocnt    <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + CLR_W'(1);
            end
            if (q_push) begin
                r_owp <= r_owp + OQ_PTR_W'(1);
            end
            if (q_pop) begin
                r_orp <= r_orp + OQ_PTR_W'(1);
            end
            if (q_push && !q_pop) begin
                r_ocnt <= r_ocnt + OQ_CNT_W'(1);
            end else if (q_pop && !q_push) begin
                r_ocnt <= r_ocnt - OQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit <= n_unit;
        r_fn   <= n_fn;
        r_a16  <= n_a16;
        r_idx  <= n_idx;
        r_left <= n_left;
        if (issue) begin
            r_p_unit <= r_unit;
            r_p_fn   <= r_fn;
            r_p_last <= (r_left == QTY_W'(1));
        end
        if (q_push) begin
            r_oq[r_owp] <= q_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/modbus_register_server.sv =====
// Modbus holding-register server over a store of STORE_DEPTH 16-bit words.
// Request channel: queue-like, push/full; a request transfers on a rising
// edge with push high and full low. Result channel: empty/pop; the oldest
// result sits on o_rsp while empty is low and transfers when pop is high.
// Reads (functions 3 and 4) give one result per register, last flagged;
// a write (function 6) stores data_high:data_low and echoes it; everything
// else gives a single error or empty result.
// A single-result request passes from the command queue to the result queue;
// a read's words pass through the sequencer and the registered store read
// before the result queue, one word per cycle while that queue has room.
// The single store port and sequencer keep the back end on one request at a
// time; a single-result request straight after a read waits while the
// read's last word enters the result queue.
// A two-entry command queue lets requests transfer while the back end works.
// Reset: synchronous, active low; afterwards the store is cleared by a pass
// over all STORE_DEPTH words (1024 here), one word per cycle, with full held high.
// Receiver stall: the four-entry result queue fills, the back end holds,
// then the command queue fills and full rises; nothing is dropped.
`default_nettype none

module modbus_register_server import mbrs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic      full,
    input  wire t_req i_req,
    output logic      empty,
    input  wire logic pop,
    output t_rsp      o_rsp
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;
    logic clearing;

    // Front end: classify and queue requests
    mbrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_req       (i_req),
        .i_hold      (clearing),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back end: store access, result sequencing and result queue
    mbrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_clearing  (clearing),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/mbrs_checker.sv =====
`default_nettype none

module mbrs_checker import mbrs_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic full,
    input wire logic empty,
    input wire logic pop,
    input wire t_rsp o_rsp
);

    // Reset empties the result side and holds off requests for the clear pass
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> full && empty)
        else $error("reset did not hold full and clear results");

    // A result without a register value is always the final one and carries zero
    a_noword_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_rsp.word_valid |-> o_rsp.last && o_rsp.data_word == 16'h0000)
        else $error("result without word not last or non-zero");

    // Error results carry no word
    a_err_noword: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_rsp.status != ST_OK |-> !o_rsp.word_valid)
        else $error("error result flagged with word");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_rsp.status == ST_OK || o_rsp.status == ST_BAD_FUNCTION ||
                   o_rsp.status == ST_BAD_VALUE)
        else $error("unknown status code");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_rsp))
        else $error("stalled result changed");

endmodule

bind modbus_register_server mbrs_checker u_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;
    import mbrs_pkg::*;

    // Generous ceiling: the clearing pass after reset, then every request
    // at its slowest with random sender gaps and receiver stalls.
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_req i_req   = '0;
    logic full;
    logic empty;
    t_rsp o_rsp;

    // Shadow copy of the register store, updated in transfer order
    logic [15:0] shadow_regs [STORE_DEPTH];
    // Replies still owed by the server, oldest first
    t_rsp owed_replies [$];

    int fail_count  = 0;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    modbus_register_server dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_rsp   (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // Abort the run if the server stops making progress.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver side: stall at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Work out the replies owed for one transferred request and apply any
    // write to the shadow store, so that later reads see it.
    task automatic predict_replies(input t_req r);
        t_rsp        rsp;
        logic [15:0] addr;
        int          n;
        rsp               = '0;
        rsp.unit_echo     = r.unit_address;
        rsp.function_echo = r.function_code;
        rsp.last          = 1'b1;
        n                 = int'(r.quantity);
        if (r.function_code == FN_READ_HOLDING || r.function_code == FN_READ_INPUT) begin
            if (n > MAX_READ_WORDS) begin
                rsp.status   = ST_BAD_VALUE;
                owed_replies = {owed_replies, rsp};
            end else if (n == 0) begin
                rsp.status   = ST_OK;
                owed_replies = {owed_replies, rsp};
            end else begin
                // Addresses wrap at 16 bits before folding onto the store
                for (int i = 0; i < n; i++) begin
                    addr           = r.start_address + 16'(i);
                    rsp.status     = ST_OK;
                    rsp.word_valid = 1'b1;
                    rsp.data_word  = shadow_regs[int'(addr) % STORE_DEPTH];
                    rsp.last       = (i == n - 1);
                    owed_replies   = {owed_replies, rsp};
                end
            end
        end else if (r.function_code == FN_WRITE_SINGLE) begin
            if (r.data_count >= 8'd2) begin
                rsp.status     = ST_OK;
                rsp.word_valid = 1'b1;
                rsp.data_word  = {r.data_high, r.data_low};
                shadow_regs[int'(r.start_address) % STORE_DEPTH] = rsp.data_word;
            end else begin
                rsp.status = ST_BAD_VALUE;
            end
            owed_replies = {owed_replies, rsp};
        end else begin
            rsp.status   = ST_BAD_FUNCTION;
            owed_replies = {owed_replies, rsp};
        end
    endtask

    // Check every reply transfer against the oldest owed reply. Values read
    // here are those from before the edge, so the sample is race free.
    always @(posedge i_clk) begin
        t_rsp want;
        logic bad;
        if (i_rst_n && pop && !empty) begin
            if (owed_replies.size() == 0) begin
                fail_count <= fail_count + 1;
                if (fail_count < MAX_REPORTS) begin
                    $display("unexpected reply: unit %h fn %h status %0d valid %0b",
                             o_rsp.unit_echo, o_rsp.function_echo, o_rsp.status,
                             o_rsp.word_valid, " word %h last %0b",
                             o_rsp.data_word, o_rsp.last);
                end
            end else begin
                want = owed_replies.pop_front();
                bad  = (o_rsp.unit_echo !== want.unit_echo)
                    || (o_rsp.function_echo !== want.function_echo)
                    || (o_rsp.status !== want.status)
                    || (o_rsp.word_valid !== want.word_valid)
                    || (o_rsp.data_word !== want.data_word)
                    || (o_rsp.last !== want.last);
                if (bad) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < MAX_REPORTS) begin
                        $display("reply mismatch: expected unit %h fn %h status %0d",
                                 want.unit_echo, want.function_echo, want.status,
                                 " valid %0b word %h last %0b",
                                 want.word_valid, want.data_word, want.last);
                        $display("                got      unit %h fn %h status %0d",
                                 o_rsp.unit_echo, o_rsp.function_echo, o_rsp.status,
                                 " valid %0b word %h last %0b",
                                 o_rsp.word_valid, o_rsp.data_word, o_rsp.last);
                    end
                end
            end
        end
    end

    function automatic t_req make_req(input logic [7:0] unit, input logic [7:0] fn,
                                      input logic [15:0] start, input logic [15:0] qty,
                                      input logic [7:0] count, input logic [7:0] hi,
                                      input logic [7:0] lo);
        t_req r;
        r.unit_address  = unit;
        r.function_code = fn;
        r.start_address = start;
        r.quantity      = qty;
        r.data_count    = count;
        r.data_high     = hi;
        r.data_low      = lo;
        return r;
    endfunction

    // Send one request. Idle first at the phase rate; push is left high on
    // return so back-to-back requests never drop it for a cycle. Full is
    // sampled as it stood before each edge.
    task automatic send_request(input t_req r);
        while ($urandom_range(0, 99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_replies(r);
    endtask

    // Hold off the sender until every owed reply has come back.
    task automatic drain_replies();
        push <= 1'b0;
        @(posedge i_clk);
        while (owed_replies.size() != 0) @(posedge i_clk);
    endtask

    // Addresses: mostly a small hot window aliased across the 16-bit space,
    // so reads find earlier writes; some fully random, some at the top edge.
    function automatic logic [15:0] pick_address();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            return 16'($urandom_range(0, 31) + ($urandom_range(0, 63) << 10));
        end else if (sel < 80) begin
            return 16'($urandom_range(0, 65535));
        end
        return 16'($urandom_range(65520, 65535));
    endfunction

    function automatic logic [15:0] pick_quantity();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 16'($urandom_range(1, 4));
        if (sel < 80) return 16'($urandom_range(0, 16));
        if (sel < 92) return 16'($urandom_range(17, MAX_READ_WORDS));
        if (sel < 95) return 16'(MAX_READ_WORDS + 1);
        return 16'($urandom_range(MAX_READ_WORDS + 1, 65535));
    endfunction

    function automatic logic [7:0] pick_count();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 75) return 8'($urandom_range(2, 4));
        if (sel < 85) return 8'($urandom_range(0, 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // Writes with extreme words and addresses, then reads that cross the
    // 16-bit wrap and the aliasing of addresses beyond the store.
    task automatic test_write_readback();
        send_request(make_req(8'h00, FN_READ_HOLDING, 16'h0000, 16'd4, 8'd0, 8'h00, 8'h00));
        send_request(make_req(8'hFF, FN_WRITE_SINGLE, 16'h0000, 16'd0, 8'd2, 8'hFF, 8'hFF));
        send_request(make_req(8'h5A, FN_WRITE_SINGLE, 16'hFFFF, 16'hFFFF, 8'd2, 8'h12, 8'h34));
        // Extra data bytes beyond the second are ignored
        send_request(make_req(8'hA5, FN_WRITE_SINGLE, 16'h0001, 16'd0, 8'd255, 8'h80, 8'h01));
        send_request(make_req(8'h01, FN_READ_INPUT, 16'hFFFF, 16'd3, 8'd0, 8'h00, 8'h00));
        // Address beyond the store folds back onto index 2
        send_request(make_req(8'h02, FN_WRITE_SINGLE, 16'd1026, 16'd0, 8'd3, 8'h00, 8'h00));
        send_request(make_req(8'h03, FN_READ_HOLDING, 16'd64512, 16'(MAX_READ_WORDS),
                              8'd0, 8'h00, 8'h00));
        send_request(make_req(8'h04, FN_READ_HOLDING, 16'd2, 16'd1, 8'hFF, 8'hFF, 8'hFF));
    endtask

    // Empty and overlong reads, short writes and unknown functions.
    task automatic test_error_replies();
        send_request(make_req(8'h10, FN_READ_HOLDING, 16'h1234, 16'd0, 8'd0, 8'h00, 8'h00));
        send_request(make_req(8'h11, FN_READ_INPUT, 16'hFFFF, 16'd0, 8'd0, 8'h00, 8'h00));
        send_request(make_req(8'h12, FN_READ_HOLDING, 16'h0000, 16'(MAX_READ_WORDS + 1),
                              8'd0, 8'h00, 8'h00));
        send_request(make_req(8'h13, FN_READ_INPUT, 16'h0000, 16'hFFFF, 8'd0, 8'h00, 8'h00));
        send_request(make_req(8'h14, FN_WRITE_SINGLE, 16'h0000, 16'd0, 8'd0, 8'hDE, 8'hAD));
        send_request(make_req(8'h15, FN_WRITE_SINGLE, 16'h0001, 16'd0, 8'd1, 8'hBE, 8'hEF));
        send_request(make_req(8'h16, 8'h00, 16'h0000, 16'd1, 8'd2, 8'h00, 8'h00));
        send_request(make_req(8'h17, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_req(8'h18, 8'h05, 16'h0000, 16'd1, 8'd2, 8'h00, 8'h00));
        send_request(make_req(8'h19, 8'h01, 16'h0000, 16'd1, 8'd0, 8'h00, 8'h00));
        send_request(make_req(8'h1A, 8'h10, 16'h0000, 16'd1, 8'd2, 8'h11, 8'h22));
        // Confirm that the short writes left the store alone
        send_request(make_req(8'h1B, FN_READ_HOLDING, 16'h0000, 16'd2, 8'd0, 8'h00, 8'h00));
    endtask

    // Random traffic under one idling profile: mostly well-formed reads and
    // writes on a hot address window, the rest random noise.
    task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                       input int count, input bit pause_midway);
        t_req r;
        int   sel;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        for (int k = 0; k < count; k++) begin
            sel             = $urandom_range(0, 99);
            r.unit_address  = 8'($urandom_range(0, 255));
            r.start_address = pick_address();
            r.quantity      = 16'($urandom_range(0, 65535));
            r.data_count    = 8'($urandom_range(0, 255));
            r.data_high     = 8'($urandom_range(0, 255));
            r.data_low      = 8'($urandom_range(0, 255));
            if (sel < 45) begin
                r.function_code = ($urandom_range(0, 1) != 0) ? FN_READ_HOLDING : FN_READ_INPUT;
                r.quantity      = pick_quantity();
            end else if (sel < 88) begin
                r.function_code = FN_WRITE_SINGLE;
                r.data_count    = pick_count();
            end else begin
                r.function_code = 8'($urandom_range(0, 255));
            end
            send_request(r);
            if (pause_midway && k == count / 2) drain_replies();
        end
        drain_replies();
    endtask

    initial begin
        foreach (shadow_regs[i]) shadow_regs[i] = '0;

        // Hold reset, then release; the clearing pass shows as full held high
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_write_readback();
        test_error_replies();
        drain_replies();
        test_random_traffic(0, 0, 90, 1'b0);
        test_random_traffic(67, 0, 90, 1'b1);
        test_random_traffic(0, 67, 90, 1'b0);
        test_random_traffic(37, 37, 95, 1'b0);

        // Let any stray reply surface before the verdict
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && owed_replies.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
